>>> rtl/core/mpcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcq_pkg
// Shared types, register indexes and defaults for the motion pulse confirm
// and quiet detector.
// ----------------------------------------------------------------------------
package mpcq_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef logic [TimeW-1:0]  time_ms_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONFIRM_COUNT  = 3'd0,
    CFG_CONFIRM_WINDOW = 3'd1,
    CFG_QUIET          = 3'd2,
    CFG_FINAL_WAIT     = 3'd3,
    CFG_STUCK_LOW      = 3'd4
  } cfg_idx_t;

  localparam count_t   RstConfirmCount  = 8'd3;
  localparam time_ms_t RstConfirmWindow = 32'd10000;
  localparam time_ms_t RstQuiet         = 32'd120000;
  localparam time_ms_t RstFinalWait     = 32'd30000;
  localparam time_ms_t RstStuckLow      = 32'd30000;

  typedef struct packed {
    count_t   confirm_count;
    time_ms_t confirm_window_ms;
    time_ms_t quiet_ms;
    time_ms_t final_wait_ms;
    time_ms_t stuck_low_ms;
  } cfg_t;

  typedef struct packed {
    time_ms_t now_ms;
    time_ms_t edge_sequence;
    logic     pin_low;
    logic     position_fresh;
    logic     position_known;
  } in_item_t;

  typedef struct packed {
    logic   motion_active;
    logic   candidate_pending;
    count_t candidate_count;
    logic   motion_confirmed;
    logic   candidate_rejected;
    logic   send_position;
    logic   wake_disabled;
    logic   sleep_veto;
  } result_t;

  // zero marks an idle time stamp, so a stamp taken at time zero becomes one
  function automatic time_ms_t nonzero_time(input time_ms_t t);
    nonzero_time = (t == '0) ? time_ms_t'(1) : t;
  endfunction

endpackage

>>> rtl/core/mpcq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcq_cfg
// Configuration register file: five write-only registers with reset defaults.
// ----------------------------------------------------------------------------
module mpcq_cfg
  import mpcq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CONFIRM_COUNT:  cfg_nxt.confirm_count     = cfg_wdata[CountW-1:0];
        CFG_CONFIRM_WINDOW: cfg_nxt.confirm_window_ms = cfg_wdata[TimeW-1:0];
        CFG_QUIET:          cfg_nxt.quiet_ms          = cfg_wdata[TimeW-1:0];
        CFG_FINAL_WAIT:     cfg_nxt.final_wait_ms     = cfg_wdata[TimeW-1:0];
        CFG_STUCK_LOW:      cfg_nxt.stuck_low_ms      = cfg_wdata[TimeW-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_count     <= RstConfirmCount;
      cfg_r.confirm_window_ms <= RstConfirmWindow;
      cfg_r.quiet_ms          <= RstQuiet;
      cfg_r.final_wait_ms     <= RstFinalWait;
      cfg_r.stuck_low_ms      <= RstStuckLow;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/mpcq_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcq_step
// Tracker state and the single-pass update for one poll tick: edge count,
// candidate window, quiet and final wait, stuck-low detection.
// ----------------------------------------------------------------------------
module mpcq_step
  import mpcq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  cfg_t     cfg,
  input  in_item_t item,
  output result_t  res
);

  time_ms_t seen_seq_r,   seen_seq_nxt;
  logic     was_low_r,    was_low_nxt;
  count_t   pulse_cnt_r,  pulse_cnt_nxt;
  time_ms_t win_start_r,  win_start_nxt;
  logic     pending_r,    pending_nxt;
  logic     active_r,     active_nxt;
  time_ms_t last_mot_r,   last_mot_nxt;
  time_ms_t fw_start_r,   fw_start_nxt;
  time_ms_t low_since_r,  low_since_nxt;
  logic     stuck_r,      stuck_nxt;

  time_ms_t edges_raw;
  logic     edge_seen;
  logic     edge_is_one;
  time_ms_t d_win;
  time_ms_t d_quiet;
  time_ms_t d_fw;
  time_ms_t d_low;
  logic     reopen;
  count_t   pc0;
  count_t   needed;
  count_t   taken;
  count_t   pc1;
  logic     confirmed;
  logic     rejected;
  logic     send;
  logic     fresh;
  logic     pend1;
  logic     act1;
  logic     mot_now;
  time_ms_t fw1;
  logic     win_zero;
  logic     quiet_hit;

  always_comb begin
    edges_raw   = item.edge_sequence - seen_seq_r;
    edge_is_one = (edges_raw == '0) && item.pin_low && !was_low_r;
    edge_seen   = (edges_raw != '0) || edge_is_one;
    fresh       = item.position_fresh && item.position_known;

    d_win  = item.now_ms - win_start_r;
    d_quiet = item.now_ms - last_mot_r;
    d_fw   = item.now_ms - fw_start_r;
    d_low  = item.now_ms - low_since_r;

    seen_seq_nxt  = item.edge_sequence;
    was_low_nxt   = item.pin_low;
    pulse_cnt_nxt = pulse_cnt_r;
    win_start_nxt = win_start_r;
    pending_nxt   = pending_r;
    active_nxt    = active_r;
    last_mot_nxt  = last_mot_r;
    fw_start_nxt  = fw_start_r;
    low_since_nxt = low_since_r;
    stuck_nxt     = stuck_r;

    confirmed = 1'b0;
    rejected  = 1'b0;
    send      = 1'b0;
    win_zero  = 1'b0;

    // candidate window and confirmation
    reopen = edge_seen && !active_r && (!pending_r || (d_win > cfg.confirm_window_ms));
    pc0    = reopen ? '0 : pulse_cnt_r;
    needed = (cfg.confirm_count > pc0) ? cfg.confirm_count - pc0 : '0;
    if (edge_is_one) begin
      taken = (needed != '0) ? count_t'(1) : '0;
    end else begin
      taken = (edges_raw < time_ms_t'(needed)) ? edges_raw[CountW-1:0] : needed;
    end
    pc1 = pc0 + taken;

    if (edge_seen && !active_r) begin
      pulse_cnt_nxt = pc1;
      pending_nxt   = 1'b1;
      if (reopen) begin
        win_start_nxt = item.now_ms;
        win_zero      = 1'b1;
      end
      if (pc1 >= cfg.confirm_count) begin
        confirmed     = 1'b1;
        active_nxt    = 1'b1;
        pulse_cnt_nxt = '0;
        win_start_nxt = '0;
        pending_nxt   = 1'b0;
      end
    end

    // window expiry
    pend1 = pending_nxt;
    if (pend1 && ((win_zero ? time_ms_t'(0) : d_win) >= cfg.confirm_window_ms)) begin
      rejected      = 1'b1;
      pulse_cnt_nxt = '0;
      win_start_nxt = '0;
      pending_nxt   = 1'b0;
    end

    // quiet detection and final wait
    act1    = active_nxt;
    mot_now = edge_seen && (active_r || confirmed);
    fw1     = mot_now ? '0 : fw_start_r;
    if (mot_now) begin
      last_mot_nxt = item.now_ms;
    end
    fw_start_nxt = fw1;
    quiet_hit = act1 && ((mot_now ? time_ms_t'(0) : d_quiet) >= cfg.quiet_ms);
    if (quiet_hit) begin
      if (fresh) begin
        send         = 1'b1;
        fw_start_nxt = '0;
        active_nxt   = 1'b0;
      end else if (fw1 == '0) begin
        fw_start_nxt = nonzero_time(item.now_ms);
      end else if (d_fw >= cfg.final_wait_ms) begin
        send         = item.position_known;
        fw_start_nxt = '0;
        active_nxt   = 1'b0;
      end
    end

    // stuck-low detection
    if (item.pin_low) begin
      if (low_since_r == '0) begin
        low_since_nxt = nonzero_time(item.now_ms);
      end else if (!stuck_r && (d_low >= cfg.stuck_low_ms)) begin
        stuck_nxt = 1'b1;
      end
    end else begin
      low_since_nxt = '0;
      stuck_nxt     = 1'b0;
    end

    res.motion_active      = active_nxt;
    res.candidate_pending  = pending_nxt;
    res.candidate_count    = pulse_cnt_nxt;
    res.motion_confirmed   = confirmed;
    res.candidate_rejected = rejected;
    res.send_position      = send;
    res.wake_disabled      = stuck_nxt;
    res.sleep_veto         = active_nxt || pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_seq_r  <= '0;
      was_low_r   <= 1'b0;
      pulse_cnt_r <= '0;
      win_start_r <= '0;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      last_mot_r  <= '0;
      fw_start_r  <= '0;
      low_since_r <= '0;
      stuck_r     <= 1'b0;
    end else if (step_en) begin
      seen_seq_r  <= seen_seq_nxt;
      was_low_r   <= was_low_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      win_start_r <= win_start_nxt;
      pending_r   <= pending_nxt;
      active_r    <= active_nxt;
      last_mot_r  <= last_mot_nxt;
      fw_start_r  <= fw_start_nxt;
      low_since_r <= low_since_nxt;
      stuck_r     <= stuck_nxt;
    end
  end

endmodule

>>> rtl/core/motion_pulse_confirm_and_quiet.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_pulse_confirm_and_quiet
// Motion pulse confirmation and quiet detection on poll ticks.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. A beat is held in an input
// register, then compare-and-add logic updates the tracker state and loads
// the result register, so a new tick is taken every cycle while the
// result side keeps up. A result is offered once its tick has passed through
// both the input register and the result register. The input register frees
// as soon as the result register can take its beat, so a waiting result
// holds the input back only once the input register is full as well.
// Configuration writes take effect on the next cycle and are meant for when
// no tick is in flight.
module motion_pulse_confirm_and_quiet
  import mpcq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TimeW-1:0]    in_now_ms,
  input  logic [TimeW-1:0]    in_edge_sequence,
  input  logic                in_pin_low,
  input  logic                in_position_fresh,
  input  logic                in_position_known,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_motion_active,
  output logic                out_candidate_pending,
  output logic [CountW-1:0]   out_candidate_count,
  output logic                out_motion_confirmed,
  output logic                out_candidate_rejected,
  output logic                out_send_position,
  output logic                out_wake_disabled,
  output logic                out_sleep_veto,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t     cfg;
  in_item_t item_r;
  logic     item_vld_r;
  result_t  res;
  result_t  res_r;
  logic     out_vld_r;
  logic     advance;

  assign advance  = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  mpcq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mpcq_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg),
    .item    (item_r),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms         <= in_now_ms;
      item_r.edge_sequence  <= in_edge_sequence;
      item_r.pin_low        <= in_pin_low;
      item_r.position_fresh <= in_position_fresh;
      item_r.position_known <= in_position_known;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_motion_active      = res_r.motion_active;
  assign out_candidate_pending  = res_r.candidate_pending;
  assign out_candidate_count    = res_r.candidate_count;
  assign out_motion_confirmed   = res_r.motion_confirmed;
  assign out_candidate_rejected = res_r.candidate_rejected;
  assign out_send_position      = res_r.send_position;
  assign out_wake_disabled      = res_r.wake_disabled;
  assign out_sleep_veto         = res_r.sleep_veto;

endmodule

>>> rtl/core/mpcq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcq_checker
// Port-level checks on the result channel of the motion tracker.
// ----------------------------------------------------------------------------
module mpcq_checker
  import mpcq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_motion_active,
  input logic              out_candidate_pending,
  input logic [CountW-1:0] out_candidate_count,
  input logic              out_motion_confirmed,
  input logic              out_candidate_rejected,
  input logic              out_sleep_veto
);

  a_veto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sleep_veto == (out_motion_active || out_candidate_pending)))
    else $error("sleep veto does not follow motion and candidate flags");

  a_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motion_confirmed) |->
      (!out_candidate_pending && !out_candidate_rejected))
    else $error("confirmed beat still shows a candidate");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_candidate_pending) |-> (out_candidate_count == '0))
    else $error("count held with no candidate pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_candidate_count) && $stable(out_sleep_veto)))
    else $error("stalled result beat changed");

endmodule

bind motion_pulse_confirm_and_quiet mpcq_checker u_mpcq_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_motion_active      (out_motion_active),
  .out_candidate_pending  (out_candidate_pending),
  .out_candidate_count    (out_candidate_count),
  .out_motion_confirmed   (out_motion_confirmed),
  .out_candidate_rejected (out_candidate_rejected),
  .out_sleep_veto         (out_sleep_veto)
);
